// ===== rtl/mrm_pkg.sv =====
`default_nettype none

package mrm_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W = 32;
  localparam int ROWS    = 4;
  localparam int ROW_W   = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             op;
    logic [ROW_W-1:0] row;
  } mrm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mrm_if.sv =====
`default_nettype none

interface mrm_in_if import mrm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [ROW_W-1:0]          row_index;
  logic signed [FIELD_W-1:0] elem_0;
  logic signed [FIELD_W-1:0] elem_1;
  logic signed [FIELD_W-1:0] elem_2;
  logic signed [FIELD_W-1:0] elem_3;

  modport source (output valid, operation, row_index, elem_0, elem_1, elem_2, elem_3,
                  input ready);
  modport sink   (input valid, operation, row_index, elem_0, elem_1, elem_2, elem_3,
                  output ready);
endinterface

interface mrm_out_if import mrm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [ROW_W-1:0]          out_row;
  logic signed [FIELD_W-1:0] prod_0;
  logic signed [FIELD_W-1:0] prod_1;
  logic signed [FIELD_W-1:0] prod_2;
  logic signed [FIELD_W-1:0] prod_3;

  modport source (output valid, out_row, prod_0, prod_1, prod_2, prod_3, input ready);
  modport sink   (input valid, out_row, prod_0, prod_1, prod_2, prod_3, output ready);
endinterface

`default_nettype wire

// ===== rtl/mrm_cell.sv =====
`default_nettype none

// One row k of B lives here. A multiply item picks up a[k]*B[k][j] for all
// columns and adds it to the running sums; a load item for row k writes it.
module mrm_cell import mrm_pkg::*; #(
  parameter int EW       = 32,
  parameter int ACC_W    = 66,
  parameter int CELL_IDX = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire mrm_ctl_t                        ctl_i,
  input  wire logic [ROWS-1:0][EW-1:0]         a_i,
  input  wire logic [ROWS-1:0][ACC_W-1:0]      psum_i,
  output      mrm_ctl_t                        ctl_o,
  output      logic [ROWS-1:0][EW-1:0]         a_o,
  output      logic [ROWS-1:0][ACC_W-1:0]      psum_o
);

  logic [EW-1:0]               brow_r [ROWS];
  mrm_ctl_t                    ctl1_r, ctl2_r;
  logic [ROWS-1:0][EW-1:0]     a1_r, a2_r;
  logic [ROWS-1:0][ACC_W-1:0]  psum1_r, sum_r, sum_nxt;
  logic signed [2*EW-1:0]      prod_r [ROWS];
  logic signed [2*EW-1:0]      prod_nxt [ROWS];
  logic                        wr_row;

  assign wr_row = en && ctl_i.vld && (ctl_i.op == OP_LOAD) &&
                  (ctl_i.row == ROW_W'(CELL_IDX));

  always_comb begin
    for (int j = 0; j < ROWS; j++) begin
      prod_nxt[j] = $signed(a_i[CELL_IDX]) * $signed(brow_r[j]);
      sum_nxt[j]  = ACC_W'($signed(psum1_r[j]) + ACC_W'(prod_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < ROWS; j++) begin
        brow_r[j] <= '0;
      end
    end else if (wr_row) begin
      for (int j = 0; j < ROWS; j++) begin
        brow_r[j] <= a_i[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  // payload: multiply stage, then accumulate stage
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= a_i;
      psum1_r <= psum_i;
      a2_r    <= a1_r;
      sum_r   <= sum_nxt;
      for (int j = 0; j < ROWS; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
  end

  assign ctl_o  = ctl2_r;
  assign a_o    = a2_r;
  assign psum_o = sum_r;

endmodule

`default_nettype wire

// ===== rtl/mrm_sat.sv =====
`default_nettype none

// Drop the fraction bits, clamp to the element range and hold the result.
module mrm_sat import mrm_pkg::*; #(
  parameter int EW        = 32,
  parameter int ACC_W     = 66,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire mrm_ctl_t                    ctl_i,
  input  wire logic [ROWS-1:0][ACC_W-1:0]  psum_i,
  output      logic                        out_vld,
  output      logic [ROW_W-1:0]            out_row,
  output      logic [ROWS-1:0][FIELD_W-1:0] prod
);

  localparam logic signed [ACC_W-1:0] MAX_V = {{(ACC_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN_V = ~MAX_V;

  logic                          out_vld_r;
  logic [ROW_W-1:0]              row_r;
  logic [ROWS-1:0][FIELD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       shr [ROWS];
  logic [EW-1:0]                 sat [ROWS];

  always_comb begin
    for (int j = 0; j < ROWS; j++) begin
      shr[j] = $signed(psum_i[j]) >>> FRAC_BITS;
      if (shr[j] > MAX_V) begin
        sat[j] = MAX_V[EW-1:0];
      end else if (shr[j] < MIN_V) begin
        sat[j] = MIN_V[EW-1:0];
      end else begin
        sat[j] = shr[j][EW-1:0];
      end
      prod_nxt[j] = FIELD_W'($signed(sat[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_i.vld && (ctl_i.op == OP_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r  <= ctl_i.row;
      prod_r <= prod_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_row = row_r;
  assign prod    = prod_r;

endmodule

`default_nettype wire

// ===== rtl/matrix4_row_multiply.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation, row_index, elem_0..elem_3
// out_ch    out  valid/ready    out_row, prod_0..prod_3
//
// One item per cycle while out_ch is not stalled. Nine register stages: two in
// each of the four row cells (multiply, accumulate), then the shift/saturate
// output register. A multiply row passes through all of them before it shows on
// out_ch. Loads travel the same chain and give no result.
// Reset clears B to zero and empties the pipeline. When out_ch holds a result
// that is not taken, the whole chain holds and in_ch.ready drops.
module matrix4_row_multiply import mrm_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrm_in_if.sink      in_ch,
  mrm_out_if.source   out_ch
);

  localparam int EW    = (ELEM_WIDTH < FIELD_W) ? ELEM_WIDTH : FIELD_W;
  localparam int ACC_W = 2 * EW + 2;

  logic                        en;
  logic                        out_vld;
  mrm_ctl_t                    ctl_w  [ROWS+1];
  logic [ROWS-1:0][EW-1:0]     a_w    [ROWS+1];
  logic [ROWS-1:0][ACC_W-1:0]  psum_w [ROWS+1];
  logic [ROWS-1:0][FIELD_W-1:0] prod;

  assign en = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  assign ctl_w[0].vld = in_ch.valid;
  assign ctl_w[0].op  = in_ch.operation;
  assign ctl_w[0].row = in_ch.row_index;
  assign a_w[0][0]    = in_ch.elem_0[EW-1:0];
  assign a_w[0][1]    = in_ch.elem_1[EW-1:0];
  assign a_w[0][2]    = in_ch.elem_2[EW-1:0];
  assign a_w[0][3]    = in_ch.elem_3[EW-1:0];
  assign psum_w[0]    = '0;

  for (genvar k = 0; k < ROWS; k++) begin : g_cell
    mrm_cell #(
      .EW       (EW),
      .ACC_W    (ACC_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_w[k]),
      .a_i    (a_w[k]),
      .psum_i (psum_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .a_o    (a_w[k+1]),
      .psum_o (psum_w[k+1])
    );
  end

  mrm_sat #(
    .EW        (EW),
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_w[ROWS]),
    .psum_i  (psum_w[ROWS]),
    .out_vld (out_vld),
    .out_row (out_ch.out_row),
    .prod    (prod)
  );

  assign out_ch.valid  = out_vld;
  assign out_ch.prod_0 = prod[0];
  assign out_ch.prod_1 = prod[1];
  assign out_ch.prod_2 = prod[2];
  assign out_ch.prod_3 = prod[3];

endmodule

`default_nettype wire
